// File: design/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg: shared types and constants of the PID controller
// Register indexes, configuration bundle, sequencer states and the request
// and response bundles of the shared multiplier.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  // integrator width
  localparam int unsigned SUM_WIDTH = 48;

  // fixed field widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COEF_W  = 17;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned FRAC_W  = 16;

  // shared multiplier: magnitude operands, product, scaled magnitude
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned MAG_W   = 62;

  // saturated product magnitude, 2^61
  localparam logic [MAG_W-1:0] TERM_LIM = {1'b1, {(MAG_W-1){1'b0}}};

  // filter coefficient of one (no filtering)
  localparam logic [COEF_W-1:0] COEF_ONE = 17'h1_0000;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I_DT      = 3'd1,
    REG_GAIN_D_OVER_DT = 3'd2,
    REG_FILTER_COEF    = 3'd3,
    REG_OUT_MAX        = 3'd4,
    REG_OUT_MIN        = 3'd5
  } cfg_idx_e;

  // configuration bundle
  typedef struct packed {
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i_dt;
    logic signed [DATA_W-1:0] gain_d_over_dt;
    logic        [COEF_W-1:0] filter_coef;
    logic signed [DATA_W-1:0] out_max;
    logic signed [DATA_W-1:0] out_min;
  } cfg_t;

  // multiplier issue: magnitudes, result sign, forced saturation
  typedef struct packed {
    logic               load;
    logic [MUL_A_W-1:0] a_mag;
    logic [MUL_B_W-1:0] b_mag;
    logic               neg;
    logic               sat;
  } mul_req_t;

  // multiplier result: (a*b)/2^16 magnitude and its sign
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
  } mul_rsp_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_FISS,
    S_FWAIT,
    S_FUPD,
    S_ESET,
    S_ISS_D,
    S_ISS_I,
    S_ACC_D,
    S_ACC_I,
    S_DONE
  } state_e;

endpackage

// File: design/pid_controller_antiwindup.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup: fixed-point PID controller with clamping
// anti-windup
// Each slave-side transaction carries a setpoint and a measurement (signed
// Q16.16); each gives one master-side transaction with the clamped drive and
// two flags. The error is low-pass filtered, the derivative is re-based when
// the setpoint changes, the integrator saturates at SUM_WIDTH bits and is held
// on the next step when the output clamps with the error's sign. The
// sequencer passes the filter product and then the P, D and I products
// through a single shared multiplier with two register stages. A new item
// is taken while the previous result still waits; if that result is still
// not taken when the next is done, the block waits for it. Configuration
// writes are always accepted and belong to idle periods.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] setpoint, [63:32] measurement
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] drive
  output logic [1:0]  m_axis_tuser    // [0] clamped, [1] windup_hold
);
  import pidaw_pkg::*;

  cfg_t               cfg_q;
  logic signed [31:0] drive;
  logic               clamped;
  logic               windup_hold;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= '0;
      cfg_q.gain_i_dt      <= '0;
      cfg_q.gain_d_over_dt <= '0;
      cfg_q.filter_coef    <= COEF_ONE;
      cfg_q.out_max        <= 32'sh7FFF_FFFF;
      cfg_q.out_min        <= 32'sh8000_0000;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_GAIN_P:         cfg_q.gain_p         <= cfg_data_i;
        REG_GAIN_I_DT:      cfg_q.gain_i_dt      <= cfg_data_i;
        REG_GAIN_D_OVER_DT: cfg_q.gain_d_over_dt <= cfg_data_i;
        REG_FILTER_COEF:    cfg_q.filter_coef    <= cfg_data_i[COEF_W-1:0];
        REG_OUT_MAX:        cfg_q.out_max        <= cfg_data_i;
        REG_OUT_MIN:        cfg_q.out_min        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  pidaw_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .setpoint_i    (s_axis_tdata[31:0]),
    .measurement_i (s_axis_tdata[63:32]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .drive_o       (drive),
    .clamped_o     (clamped),
    .windup_hold_o (windup_hold)
  );

  // result packing
  assign m_axis_tdata = drive;
  assign m_axis_tuser = {windup_hold, clamped};

endmodule

// File: design/pidaw_mul.sv
// ----------------------------------------------------------------------------
// pidaw_mul: shared fixed-point multiplier
// Two-stage unit: operand registers, then product register. Gives the
// Q16.16 scaled magnitude from the product register, saturated when forced.
// ----------------------------------------------------------------------------
module pidaw_mul (
  input  logic                clk_i,
  input  pidaw_pkg::mul_req_t req_i,
  output pidaw_pkg::mul_rsp_t rsp_o
);
  import pidaw_pkg::*;

  logic [MUL_A_W-1:0] a_q;
  logic [MUL_B_W-1:0] b_q;
  logic               neg_q;
  logic               sat_q;
  logic [PROD_W-1:0]  prod_q;
  logic               pneg_q;
  logic               psat_q;

  // operand stage, loaded on issue; product stage every cycle
  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      a_q   <= req_i.a_mag;
      b_q   <= req_i.b_mag;
      neg_q <= req_i.neg;
      sat_q <= req_i.sat;
    end
    prod_q <= PROD_W'(a_q) * PROD_W'(b_q);
    pneg_q <= neg_q;
    psat_q <= sat_q;
  end

  // drop the fraction bits, force the limit when flagged
  assign rsp_o.mag = psat_q ? TERM_LIM : MAG_W'(prod_q[PROD_W-1:FRAC_W]);
  assign rsp_o.neg = pneg_q;

endmodule

// File: design/pidaw_core.sv
// ----------------------------------------------------------------------------
// pidaw_core: PID sequencer and datapath
// Runs the filter product and the three gain products through the shared
// multiplier, keeps the controller state and holds the result register.
// ----------------------------------------------------------------------------
module pidaw_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pidaw_pkg::cfg_t          cfg_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [31:0]       setpoint_i,
  input  logic signed [31:0]       measurement_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [31:0]       drive_o,
  output logic                     clamped_o,
  output logic                     windup_hold_o
);
  import pidaw_pkg::*;

  localparam int unsigned ESW = SUM_WIDTH + 1;
  localparam logic signed [SUM_WIDTH-1:0] ES_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] ES_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  // saturate to 32 signed bits
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // magnitude of a 32 bit signed value
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? unsigned'(-v) : unsigned'(v);
    return r;
  endfunction

  state_e state_q, state_d;

  // controller state
  logic signed [31:0]          filt_q;
  logic signed [31:0]          last_err_q;
  logic signed [31:0]          last_sp_q;
  logic signed [SUM_WIDTH-1:0] es_q;
  logic                        integ_on_q;

  // per-item work registers
  logic signed [31:0] raw_q;
  logic               chg_q;
  logic signed [32:0] diff_q;
  logic signed [32:0] d_q;
  logic signed [63:0] total_q;

  // result register
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] drive_q;
  logic               clamped_q;
  logic               hold_q;

  // control
  logic     in_ready;
  logic     in_fire;
  logic     out_load;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  // datapath nets
  logic signed [35:0]          raw_wide;
  logic signed [32:0]          diff_d;
  logic [32:0]                 diff_mag;
  logic [COEF_W-1:0]           coef_eff;
  logic signed [35:0]          filt_ext;
  logic signed [35:0]          fterm;
  logic signed [35:0]          fsum;
  logic signed [31:0]          filt_new;
  logic [31:0]                 e_mag;
  logic [31:0]                 gp_mag;
  logic [31:0]                 gi_mag;
  logic [31:0]                 gd_mag;
  logic signed [31:0]          lef;
  logic signed [32:0]          d_d;
  logic [32:0]                 d_mag;
  logic [SUM_WIDTH-1:0]        es_mag;
  logic                        es_big;
  logic signed [ESW-1:0]       es_sum;
  logic                        es_ovf;
  logic signed [SUM_WIDTH-1:0] es_new;
  logic signed [63:0]          term64;
  logic signed [63:0]          acc_base;
  logic signed [63:0]          acc_sum;
  logic signed [31:0]          omax;
  logic signed [31:0]          omin;
  logic                        gt;
  logic                        lt;
  logic                        limited;
  logic signed [31:0]          drive_d;
  logic                        e_pos, e_neg, t_pos, t_neg;
  logic                        hold;

  pidaw_mul u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  // raw error and filter difference
  assign raw_wide = 36'(setpoint_i) - 36'(measurement_i);
  assign diff_d   = 33'(raw_q) - 33'(filt_q);
  assign diff_mag = diff_q[32] ? -diff_q : diff_q;
  assign coef_eff = (cfg_i.filter_coef > COEF_ONE) ? COEF_ONE : cfg_i.filter_coef;

  // filter update: filt + signed product
  assign filt_ext = 36'(filt_q);
  assign fterm    = {1'b0, mul_rsp.mag[34:0]};
  assign fsum     = mul_rsp.neg ? filt_ext - fterm : filt_ext + fterm;
  assign filt_new = sat32(fsum);

  // operand magnitudes
  assign e_mag  = mag32(filt_q);
  assign gp_mag = mag32(signed'(cfg_i.gain_p));
  assign gi_mag = mag32(signed'(cfg_i.gain_i_dt));
  assign gd_mag = mag32(signed'(cfg_i.gain_d_over_dt));

  // derivative input, re-based on a setpoint change
  assign lef   = chg_q ? filt_q : last_err_q;
  assign d_d   = 33'(filt_q) - 33'(lef);
  assign d_mag = d_q[32] ? -d_q : d_q;

  // integrator magnitude; at or above 2^32 the product saturates unless the gain is zero
  assign es_mag = es_q[SUM_WIDTH-1] ? unsigned'(-es_q) : unsigned'(es_q);
  assign es_big = ESW'(es_mag) >= ESW'({1'b1, 32'd0});

  // saturating integrator add
  assign es_sum = ESW'(es_q) + ESW'(filt_q);
  assign es_ovf = es_sum[SUM_WIDTH] != es_sum[SUM_WIDTH-1];
  assign es_new = es_ovf ? (es_sum[SUM_WIDTH] ? ES_MIN : ES_MAX) : es_sum[SUM_WIDTH-1:0];

  // P+I+D accumulation
  assign term64   = {2'b00, mul_rsp.mag};
  assign acc_base = (state_q == S_ISS_I) ? '0 : total_q;
  assign acc_sum  = mul_rsp.neg ? acc_base - term64 : acc_base + term64;

  // clamp, lower limit last
  assign omax    = signed'(cfg_i.out_max);
  assign omin    = signed'(cfg_i.out_min);
  assign gt      = total_q > 64'(omax);
  assign lt      = gt ? (omax < omin) : (total_q < 64'(omin));
  assign limited = gt | lt;
  assign drive_d = lt ? omin : (gt ? omax : total_q[31:0]);

  // anti-windup: clamped with error and sum of one sign
  assign e_pos = !filt_q[31] && (filt_q != '0);
  assign e_neg = filt_q[31];
  assign t_pos = !total_q[63] && (total_q != '0);
  assign t_neg = total_q[63];
  assign hold  = ((e_pos && t_pos) || (e_neg && t_neg)) && limited;

  // next state, multiplier issue, handshakes
  always_comb begin
    state_d = state_q;
    mul_req = '0;
    in_ready = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: state_d = S_FISS;
      S_FISS: begin
        mul_req.load  = 1'b1;
        mul_req.a_mag = diff_mag;
        mul_req.b_mag = MUL_B_W'(coef_eff);
        mul_req.neg   = diff_q[32];
        state_d = S_FWAIT;
      end
      S_FWAIT: state_d = S_FUPD;
      S_FUPD: state_d = S_ESET;
      S_ESET: begin
        mul_req.load  = 1'b1;
        mul_req.a_mag = {1'b0, e_mag};
        mul_req.b_mag = gp_mag;
        mul_req.neg   = filt_q[31] ^ cfg_i.gain_p[31];
        state_d = S_ISS_D;
      end
      S_ISS_D: begin
        mul_req.load  = 1'b1;
        mul_req.a_mag = d_mag;
        mul_req.b_mag = gd_mag;
        mul_req.neg   = d_q[32] ^ cfg_i.gain_d_over_dt[31];
        state_d = S_ISS_I;
      end
      S_ISS_I: begin
        mul_req.load  = 1'b1;
        mul_req.a_mag = {1'b0, es_mag[31:0]};
        mul_req.b_mag = gi_mag;
        mul_req.neg   = es_q[SUM_WIDTH-1] ^ cfg_i.gain_i_dt[31];
        mul_req.sat   = es_big && (cfg_i.gain_i_dt != '0);
        state_d = S_ACC_D;
      end
      S_ACC_D: state_d = S_ACC_I;
      S_ACC_I: state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_fire = in_ready && in_valid_i;

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      filt_q      <= '0;
      last_err_q  <= '0;
      last_sp_q   <= '0;
      es_q        <= '0;
      integ_on_q  <= 1'b1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        last_sp_q <= setpoint_i;
      end
      if (state_q == S_FUPD) begin
        filt_q <= filt_new;
      end
      if (state_q == S_ESET) begin
        last_err_q <= filt_q;
        if (integ_on_q) begin
          es_q <= es_new;
        end
      end
      if (out_load) begin
        integ_on_q <= !hold;
      end
    end
  end

  // per-item work registers and result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      raw_q <= sat32(raw_wide);
      chg_q <= setpoint_i != last_sp_q;
    end
    if (state_q == S_DIFF) begin
      diff_q <= diff_d;
    end
    if (state_q == S_ESET) begin
      d_q <= d_d;
    end
    if (state_q == S_ISS_I || state_q == S_ACC_D || state_q == S_ACC_I) begin
      total_q <= acc_sum;
    end
    if (out_load) begin
      drive_q   <= drive_d;
      clamped_q <= limited;
      hold_q    <= hold;
    end
  end

  assign in_ready_o    = in_ready;
  assign out_valid_o   = out_valid_q;
  assign drive_o       = drive_q;
  assign clamped_o     = clamped_q;
  assign windup_hold_o = hold_q;

  // a hold is only ever reported together with a clamp
  a_hold_needs_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (clamped_q || !hold_q))
    else $error("windup hold without clamp");

  // the filter state moves only in its update step
  a_filt_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_FUPD) |=> $stable(filt_q))
    else $error("filtered error changed outside update step");

  // a held integrator keeps its value
  a_es_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ESET && !integ_on_q) |=> $stable(es_q))
    else $error("integrator changed while held");

endmodule

// File: tb/pid_controller_antiwindup_tb.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_tb: self-checking bench of the PID controller
// Drives setpoint/measurement transactions through directed cases (reset
// gains, clamping and windup hold, filter settings, spare register indexes),
// an output stall that backs the block up, random register settings with
// random samples, and a large integrator seen through a tiny integral gain.
// A cycle-free predictor computes each drive and flag pair at acceptance; a
// monitor compares every result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_tb;
  import pidaw_pkg::*;

  // integrator and word limits, product magnitude cap (2^61)
  localparam longint      ACC_MAX     = (64'sd1 <<< (SUM_WIDTH - 1)) - 1;
  localparam longint      ACC_MIN     = -ACC_MAX - 1;
  localparam longint      WORD_MAX    = 64'sd2147483647;
  localparam longint      WORD_MIN    = -64'sd2147483648;
  localparam logic [63:0] PRODUCT_CAP = 64'h2000_0000_0000_0000;

  // unused register indexes, writes there must be dropped
  localparam logic [2:0] IDX_SPARE_LO = 3'd6;
  localparam logic [2:0] IDX_SPARE_HI = 3'd7;

  localparam logic [31:0] Q_ONE          = 32'h0001_0000;
  localparam int unsigned RANDOM_SAMPLES = 500;
  localparam int unsigned PHASES         = 5;

  typedef struct packed {
    logic [31:0] drive;
    logic        clamped;
    logic        hold;
  } pid_result_t;

  // DUT ports
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i   = '0;
  logic [31:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // predictor registers and state, at their reset values
  longint      kp         = 0;
  longint      ki_dt      = 0;
  longint      kd_dt      = 0;
  logic [16:0] lp_coef    = COEF_ONE;
  longint      lim_hi     = WORD_MAX;
  longint      lim_lo     = WORD_MIN;
  longint      flt_err    = 0;
  longint      prev_err   = 0;
  longint      prev_sp    = 0;
  longint      err_acc    = 0;
  bit          acc_enable = 1'b1;

  pid_result_t pending_drives[$];

  bit          tx_idle_en      = 1'b1;
  bit          rx_idle_en      = 1'b1;
  int unsigned rx_hold_req     = 0;
  int unsigned mismatches      = 0;
  int unsigned samples_sent    = 0;
  int unsigned results_checked = 0;
  int unsigned settings_loaded = 0;

  pid_controller_antiwindup dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic longint clip_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // (a*b)/2^16 toward zero, magnitude capped at 2^61; a multiplicand wider
  // than 32 bits against a nonzero operand goes straight to the cap
  function automatic longint q16_product(input longint a, input longint b);
    logic [63:0]  mag_a;
    logic [63:0]  mag_b;
    logic [63:0]  mag;
    logic [127:0] wide;
    bit           neg;
    neg   = (a < 0) != (b < 0);
    mag_a = (a < 0) ? -a : a;
    mag_b = (b < 0) ? -b : b;
    if (mag_b[63:32] != 0 && mag_a != 0) begin
      mag = PRODUCT_CAP;
    end else begin
      wide = ({64'd0, mag_a} * {64'd0, mag_b}) >> 16;
      mag  = (wide > {64'd0, PRODUCT_CAP}) ? PRODUCT_CAP : wide[63:0];
    end
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      REG_GAIN_P:         kp      = $signed(val);
      REG_GAIN_I_DT:      ki_dt   = $signed(val);
      REG_GAIN_D_OVER_DT: kd_dt   = $signed(val);
      REG_FILTER_COEF:    lp_coef = val[16:0];
      REG_OUT_MAX:        lim_hi  = $signed(val);
      REG_OUT_MIN:        lim_lo  = $signed(val);
      default: ;
    endcase
  endfunction

  // one control step: filter, derivative re-base, integrator, P+I+D, clamp
  function automatic pid_result_t predict_drive(input logic [31:0] sp_bits,
                                                input logic [31:0] meas_bits);
    longint      sp;
    longint      meas;
    longint      raw;
    longint      coef;
    longint      e;
    longint      total;
    longint      drv;
    bit          same;
    bit          lim;
    pid_result_t res;
    sp   = $signed(sp_bits);
    meas = $signed(meas_bits);
    coef = (lp_coef > COEF_ONE) ? COEF_ONE : lp_coef;
    raw  = clip_word(sp - meas);
    e    = clip_word(flt_err + q16_product(raw - flt_err, coef));
    flt_err = e;
    // no derivative kick on a setpoint step
    if (sp != prev_sp) prev_err = e;
    if (acc_enable) begin
      if (e > 0 && err_acc > ACC_MAX - e) err_acc = ACC_MAX;
      else if (e < 0 && err_acc < ACC_MIN - e) err_acc = ACC_MIN;
      else err_acc = err_acc + e;
    end
    total = q16_product(kp, e) + q16_product(ki_dt, err_acc)
          + q16_product(kd_dt, e - prev_err);
    same = (e > 0 && total > 0) || (e < 0 && total < 0);
    // lower limit is applied last, so it wins on inverted limits
    drv = total;
    lim = 1'b0;
    if (drv > lim_hi) begin
      drv = lim_hi;
      lim = 1'b1;
    end
    if (drv < lim_lo) begin
      drv = lim_lo;
      lim = 1'b1;
    end
    acc_enable = !(same && lim);
    prev_err   = e;
    prev_sp    = sp;
    res.drive   = drv[31:0];
    res.clamped = lim;
    res.hold    = !acc_enable;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rand_span(input int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // one input transaction, with an optional random gap in front
  task automatic send_sample(input logic [31:0] sp, input logic [31:0] meas);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {meas, sp};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_drives.push_back(predict_drive(sp, meas));
    samples_sent++;
  endtask

  // stop offering and wait until every predicted result came back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_drives.size() != 0);
  endtask

  // leaves cfg_valid_i high so back-to-back writes follow without a gap
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
  endtask

  // full register set; only called on a drained block
  task automatic load_setting(input logic [31:0] p_v, input logic [31:0] i_v,
                              input logic [31:0] d_v, input logic [31:0] coef_v,
                              input logic [31:0] hi_v, input logic [31:0] lo_v);
    write_reg(REG_GAIN_P, p_v);
    write_reg(REG_GAIN_I_DT, i_v);
    write_reg(REG_GAIN_D_OVER_DT, d_v);
    write_reg(REG_FILTER_COEF, coef_v);
    write_reg(REG_OUT_MAX, hi_v);
    write_reg(REG_OUT_MIN, lo_v);
    cfg_valid_i <= 1'b0;
    settings_loaded++;
  endtask

  task automatic load_random_setting(input bit wide);
    logic [31:0] p_v;
    logic [31:0] i_v;
    logic [31:0] d_v;
    logic [31:0] coef_v;
    logic [31:0] hi_v;
    logic [31:0] lo_v;
    p_v = wide ? $urandom : rand_span(32'h4_0000);
    i_v = wide ? $urandom : rand_span(32'h1000);
    d_v = wide ? $urandom : rand_span(32'h2_0000);
    case ($urandom_range(0, 3))
      0:       coef_v = COEF_ONE;
      1:       coef_v = $urandom_range(0, 65536);
      2:       coef_v = $urandom_range(1024, 16384);
      // above one, with junk in the unused upper bits
      default: coef_v = ($urandom & 32'hFFFE_0000) | $urandom_range(65537, 131071);
    endcase
    hi_v = $urandom_range(0, 32'h40_0000);
    lo_v = -$urandom_range(0, 32'h40_0000);
    if (wide) begin
      hi_v = $urandom;
      lo_v = $urandom;
    end else if ($urandom_range(0, 3) == 0) begin
      // inverted limits
      hi_v = -hi_v;
      lo_v = -lo_v;
    end
    load_setting(p_v, i_v, d_v, coef_v, hi_v, lo_v);
  endtask

  // mostly small tracking errors with a held setpoint half the time; now and
  // then a full-range pair whose errors roughly cancel in the integrator
  task automatic run_random_phase(input int unsigned count);
    logic [31:0] sp;
    logic [31:0] a;
    logic [31:0] b;
    int unsigned done;
    sp   = '0;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 15) == 0) begin
        a = $urandom;
        b = $urandom;
        send_sample(a, b);
        send_sample(b, a);
        sp   = b;
        done = done + 2;
      end else begin
        if ($urandom_range(0, 1) == 1) sp = rand_span(32'h10_0000);
        send_sample(sp, sp + rand_span(32'h8_0000));
        done++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset registers: zero gains, so drive stays zero; error extremes saturate
  task automatic test_reset_state();
    send_sample(32'h0000_0000, 32'h0000_0000);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'hAAAA_AAAA, 32'h5555_5555);
    send_sample(32'h5555_5555, 32'hAAAA_AAAA);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();
  endtask

  task automatic test_clamp_hold();
    // limits at +/-8.0: clamp both ways with windup hold, then a free step
    load_setting(Q_ONE, 32'h0000_0100, 32'h0000_8000, COEF_ONE,
                 32'h0008_0000, 32'hFFF8_0000);
    send_sample(32'h0014_0000, 32'h0000_0000);
    send_sample(32'h0014_0000, 32'h0000_0000);
    send_sample(32'h0000_0000, 32'h0014_0000);
    send_sample(32'h0000_0000, 32'hFFFF_0000);
    send_sample(32'h0003_0000, 32'h0001_0000);
    drain();
    // inverted limits: lower clamp wins
    load_setting(Q_ONE, 32'h0, 32'h0, COEF_ONE, 32'hFFFF_0000, Q_ONE);
    send_sample(32'h0005_0000, 32'h0000_0000);
    send_sample(32'h0000_0000, 32'h0000_0000);
    drain();
    // gains and limits at their extremes, products saturate
    load_setting(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, COEF_ONE,
                 32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(Q_ONE, 32'h0000_0000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    drain();
  endtask

  task automatic test_filter();
    // zero coefficient freezes the filtered error
    load_setting(Q_ONE, 32'h0, Q_ONE, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h0010_0000, 32'h0000_0000);
    send_sample(32'h0000_0000, 32'h0000_0000);
    drain();
    load_setting(Q_ONE, 32'h0, Q_ONE, 32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h0010_0000, 32'h0000_0000);
    send_sample(32'h0010_0000, 32'h0000_0000);
    drain();
    // coefficients above one act as one
    load_setting(Q_ONE, 32'h0, Q_ONE, 32'h0001_0001, 32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'hFFF0_0000, 32'h0000_0000);
    drain();
    load_setting(Q_ONE, 32'h0, Q_ONE, ($urandom & 32'hFFFE_0000) | 32'h0001_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h0002_0000, 32'h0001_0000);
    drain();
  endtask

  // writes to unused indexes must leave every register as it was
  task automatic test_spare_index();
    write_reg(IDX_SPARE_LO, $urandom);
    write_reg(IDX_SPARE_HI, $urandom);
    cfg_valid_i <= 1'b0;
    send_sample(32'h0004_0000, 32'h0001_0000);
    send_sample(32'hFFFC_0000, 32'h0001_0000);
    drain();
  endtask

  // receiver stalls long enough that the block fills and stalls its input
  task automatic test_output_stall();
    load_random_setting(1'b0);
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b0;
    rx_hold_req = 80;
    repeat (12) send_sample(rand_span(32'h10_0000), rand_span(32'h10_0000));
    drain();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_random();
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES - 1) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      load_random_setting(phase == 0);
      run_random_phase(RANDOM_SAMPLES / PHASES);
      drain();
    end
  endtask

  // maximum error grows the integrator well past 32 bits, then a tiny
  // integral gain sees it: the integral product saturates, the drive clamps
  // high and the integrator is held until the error changes sign
  task automatic test_integrator_limit();
    load_setting(32'h0, 32'h0, 32'h0, COEF_ONE, 32'h7FFF_FFFF, 32'h8000_0000);
    repeat (8) send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    drain();
    load_setting(32'h0, 32'h1, 32'h0, COEF_ONE, 32'h7FFF_FFFF, 32'h8000_0000);
    repeat (2) send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    repeat (3) send_sample(32'h0000_0000, Q_ONE);
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, or a long hold on request
  // ---------------------------------------------------------------------------
  always begin
    @(posedge clk_i);
    if (rx_hold_req != 0) begin
      m_axis_tready <= 1'b0;
      repeat (rx_hold_req) @(posedge clk_i);
      rx_hold_req = 0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Result monitor
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_result
    pid_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_drives.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual %h/%b",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_drives.pop_front();
        results_checked++;
        if (m_axis_tdata !== want.drive) note_mismatch("drive", want.drive, m_axis_tdata);
        if (m_axis_tuser[0] !== want.clamped)
          note_mismatch("clamped", want.clamped, m_axis_tuser[0]);
        if (m_axis_tuser[1] !== want.hold)
          note_mismatch("windup_hold", want.hold, m_axis_tuser[1]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_clamp_hold();
    test_filter();
    test_spare_index();
    test_output_stall();
    test_random();
    test_integrator_limit();
    // let any stray result show up
    repeat (24) @(posedge clk_i);
    $display("Covered %0d samples under %0d register settings, %0d results checked.",
             samples_sent, settings_loaded, results_checked);
    $display("Included clamp/hold, filter, spare index, output stall, integrator limit.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Timeout: run did not complete.");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
